FILE: src/midi_note_event_encoder_assert.svh
// Assertion macros for the encoder checker.
`ifndef MIDI_NOTE_EVENT_ENCODER_ASSERT_SVH
`define MIDI_NOTE_EVENT_ENCODER_ASSERT_SVH

// Implication in the same cycle, ignored while reset is high.
`define MNEE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, ignored while reset is high.
`define MNEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after reset is applied.
`define MNEE_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

FILE: src/mnee_pkg.sv
`default_nettype none

package mnee_pkg;

  // Field widths
  localparam int TIME_W = 64;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int VLQ_W  = 7;
  localparam int TICK_W = 4 * VLQ_W;

  localparam int NOTE_SLOTS  = 128;
  localparam int US_PER_TICK = 25;
  localparam int QUEUE_DEPTH = 2;

  // Divider: dividend bits retired per cycle and steps per delta
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = TIME_W / BITS_PER_STEP;

  localparam logic [TICK_W-1:0] TICK_MAX   = '1;
  localparam logic [BYTE_W-1:0] STATUS_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] STATUS_OFF = 8'h80;

  typedef enum logic {
    OP_ON  = 1'b0,
    OP_OFF = 1'b1
  } opcode_t;

  // Event that changed a note's state, waiting for the back end
  typedef struct packed {
    logic              off;
    logic [TIME_W-1:0] delta;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } queue_entry_t;

  typedef struct packed {
    logic         push;
    queue_entry_t entry;
  } queue_push_t;

  // Event with its final tick count
  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              off;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } tick_item_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN
  } div_state_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_VLQ,
    EM_STATUS,
    EM_NOTE,
    EM_VEL
  } emit_state_t;

  // Index of the most significant nonzero 7-bit group (0 for small counts)
  function automatic logic [1:0] vlq_top_group(input logic [TICK_W-1:0] t);
    logic [1:0] g;
    g = 2'd0;
    if (t[TICK_W-1:VLQ_W] != '0)       g = 2'd1;
    if (t[TICK_W-1:2*VLQ_W] != '0)     g = 2'd2;
    if (t[TICK_W-1:3*VLQ_W] != '0)     g = 2'd3;
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: src/mnee_evt_if.sv
`default_nettype none

// Note event channel
interface mnee_evt_if;
  import mnee_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [TIME_W-1:0] abs_time;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;

  modport source (output valid, opcode, abs_time, note, velocity, input ready);
  modport sink   (input valid, opcode, abs_time, note, velocity, output ready);
endinterface

`default_nettype wire

FILE: src/mnee_trk_if.sv
`default_nettype none

// Track byte channel
interface mnee_trk_if;
  import mnee_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: src/midi_note_event_encoder.sv
// MIDI note event encoder: note events in, Standard MIDI File track bytes out.
// note_evt carries one event per item (opcode 0 on / 1 off, abs_time in us,
// note, velocity). track carries one byte per item; last_byte marks the
// velocity byte that ends an event. Both use valid/ready.
// An on for a sounding note or an off for a silent note is taken and gives
// no bytes. Any other event gives 4 to 7 bytes: the delta time in 25 us
// ticks as a variable-length quantity, status, note, velocity.
// The tick divider retires 8 of the 64 delta bits per cycle, then adds the
// sub-tick carry once its result register is free. A queue after the note
// check, two entries deep by default, lets events arrive while it works;
// note_evt.ready drops only when the queue is full.
// When track stalls, the byte held on the port stays, the sequencer and the
// divider finish into their own registers and then wait.
// Reset clears all note flags, the previous time and the sub-tick remainder,
// drops track.valid and empties the queue; events are taken the next cycle.
`default_nettype none

module midi_note_event_encoder #(
  parameter int UsPerTick  = mnee_pkg::US_PER_TICK,
  parameter int QueueDepth = mnee_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  mnee_evt_if.sink   note_evt,
  mnee_trk_if.source track
);
  import mnee_pkg::*;

  queue_push_t  q_push;
  queue_entry_t q_head;
  logic         q_full;
  logic         q_avail;
  logic         q_pop;
  tick_item_t   tick_item;
  logic         tick_valid;
  logic         tick_take;

  mnee_front u_front (
    .clk      (clk),
    .rst      (rst),
    .note_evt (note_evt),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  mnee_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_req (q_push),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  mnee_div #(
    .UsPerTick (UsPerTick)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .q_avail      (q_avail),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result       (tick_item),
    .result_valid (tick_valid),
    .result_take  (tick_take)
  );

  mnee_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item       (tick_item),
    .item_valid (tick_valid),
    .item_take  (tick_take),
    .track      (track)
  );

endmodule

`default_nettype wire

FILE: src/mnee_front.sv
`default_nettype none

// Front end: note state check, delta time, push to the queue
module mnee_front (
  input  logic                 clk,
  input  logic                 rst,
  mnee_evt_if.sink             note_evt,
  input  logic                 q_full,
  output mnee_pkg::queue_push_t q_push
);
  import mnee_pkg::*;

  logic [NOTE_SLOTS-1:0] sounding;
  logic [TIME_W-1:0]     prev_time;

  logic accept;
  logic is_off;
  logic pass;

  assign note_evt.ready = !q_full;
  assign accept = note_evt.valid && note_evt.ready;
  assign is_off = (note_evt.opcode == OP_OFF);
  // on passes only if silent, off only if sounding
  assign pass   = (is_off == sounding[note_evt.note]);

  // Queue entry
  always_comb begin
    q_push.push        = accept && pass;
    q_push.entry.off   = is_off;
    q_push.entry.delta = note_evt.abs_time - prev_time;
    q_push.entry.note  = note_evt.note;
    q_push.entry.vel   = note_evt.velocity;
  end

  // Note flags and time of the last passed event
  always_ff @(posedge clk) begin
    if (rst) begin
      sounding  <= '0;
      prev_time <= '0;
    end else if (q_push.push) begin
      sounding[note_evt.note] <= !is_off;
      prev_time               <= note_evt.abs_time;
    end
  end

endmodule

`default_nettype wire

FILE: src/mnee_fifo.sv
`default_nettype none

// Short register queue between front and back end (Depth >= 2)
module mnee_fifo #(
  parameter int Depth = mnee_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mnee_pkg::queue_push_t  push_req,
  output logic                   full,
  input  logic                   pop,
  output logic                   avail,
  output mnee_pkg::queue_entry_t head
);
  import mnee_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  queue_entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CntW'(Depth));
  assign avail   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push_req.push && !full;
  assign do_pop  = pop && avail;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req.entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/mnee_div.sv
`default_nettype none

// Back end, first part: delta / UsPerTick, remainder carry and saturation
module mnee_div #(
  parameter int UsPerTick = mnee_pkg::US_PER_TICK
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_avail,
  input  mnee_pkg::queue_entry_t q_head,
  output logic                   q_pop,
  output mnee_pkg::tick_item_t   result,
  output logic                   result_valid,
  input  logic                   result_take
);
  import mnee_pkg::*;

  localparam int RemW = $clog2(UsPerTick + 1);
  localparam int CntW = $clog2(DIV_STEPS);
  localparam logic [RemW:0] UsExt = (RemW + 1)'(UsPerTick);

  div_state_t state;
  div_state_t state_next;

  logic [CntW-1:0]   step_cnt;
  logic [TIME_W-1:0] dividend;
  logic [RemW-1:0]   rem;
  logic [TICK_W-1:0] quo;
  logic              ovf;
  logic              item_off;
  logic [NOTE_W-1:0] item_note;
  logic [VEL_W-1:0]  item_vel;
  logic [RemW-1:0]   acc;

  logic [RemW-1:0]   rem_step;
  logic [TICK_W-1:0] quo_step;
  logic              ovf_step;
  logic [RemW:0]     acc_sum;
  logic              carry;
  logic [RemW-1:0]   acc_next;
  logic [TICK_W-1:0] ticks_fin;
  logic              slot_free;
  logic              load_res;

  assign slot_free = !result_valid || result_take;

  // Restoring division, BITS_PER_STEP dividend bits per cycle
  always_comb begin
    logic [RemW:0] r_ext;
    logic          qb;
    rem_step = rem;
    quo_step = quo;
    ovf_step = ovf;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r_ext = {rem_step, dividend[TIME_W-1-i]};
      qb    = (r_ext >= UsExt);
      rem_step = qb ? RemW'(r_ext - UsExt) : r_ext[RemW-1:0];
      // a quotient bit shifted past bit 27 means the count saturates
      ovf_step = ovf_step | quo_step[TICK_W-1];
      quo_step = {quo_step[TICK_W-2:0], qb};
    end
  end

  // Sub-tick carry; strictly greater than one tick adds a tick
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, rem};
    carry    = (acc_sum > UsExt);
    acc_next = carry ? RemW'(acc_sum - UsExt) : acc_sum[RemW-1:0];
    if (ovf) begin
      ticks_fin = TICK_MAX;
    end else if (carry && (quo != TICK_MAX)) begin
      ticks_fin = quo + 1'b1;
    end else begin
      ticks_fin = quo;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (q_avail) state_next = DIV_RUN;
      DIV_RUN:  if (step_cnt == CntW'(DIV_STEPS - 1)) state_next = DIV_FIN;
      DIV_FIN: begin
        if (slot_free) state_next = q_avail ? DIV_RUN : DIV_IDLE;
      end
      default:  state_next = DIV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop    = 1'b0;
    load_res = 1'b0;
    unique case (state)
      DIV_IDLE: q_pop = q_avail;
      DIV_RUN:  q_pop = 1'b0;
      DIV_FIN: begin
        load_res = slot_free;
        q_pop    = slot_free && q_avail;
      end
      default: begin
        q_pop    = 1'b0;
        load_res = 1'b0;
      end
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= DIV_IDLE;
      result_valid <= 1'b0;
      acc          <= '0;
    end else begin
      state <= state_next;
      if (load_res) begin
        result_valid <= 1'b1;
        acc          <= acc_next;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dividend  <= q_head.delta;
      rem       <= '0;
      quo       <= '0;
      ovf       <= 1'b0;
      step_cnt  <= '0;
      item_off  <= q_head.off;
      item_note <= q_head.note;
      item_vel  <= q_head.vel;
    end else if (state == DIV_RUN) begin
      dividend <= dividend << BITS_PER_STEP;
      rem      <= rem_step;
      quo      <= quo_step;
      ovf      <= ovf_step;
      step_cnt <= step_cnt + 1'b1;
    end
    if (load_res) begin
      result.ticks <= ticks_fin;
      result.off   <= item_off;
      result.note  <= item_note;
      result.vel   <= item_vel;
    end
  end

endmodule

`default_nettype wire

FILE: src/mnee_emit.sv
`default_nettype none

// Back end, second part: byte sequencer with output register
module mnee_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  mnee_pkg::tick_item_t item,
  input  logic                 item_valid,
  output logic                 item_take,
  mnee_trk_if.source           track
);
  import mnee_pkg::*;

  emit_state_t state;
  emit_state_t state_next;

  logic [TICK_W-1:0] ticks;
  logic              off;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  vel;
  logic [1:0]        grp;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic              adv;
  logic              emit;
  logic [BYTE_W-1:0] byte_val;
  logic              last_val;
  logic [VLQ_W-1:0]  part;

  assign adv = !out_valid || track.ready;

  assign track.valid     = out_valid;
  assign track.out_byte  = out_byte;
  assign track.last_byte = out_last;

  // Current 7-bit group of the tick count
  always_comb begin
    unique case (grp)
      2'd0:    part = ticks[VLQ_W-1:0];
      2'd1:    part = ticks[2*VLQ_W-1:VLQ_W];
      2'd2:    part = ticks[3*VLQ_W-1:2*VLQ_W];
      default: part = ticks[4*VLQ_W-1:3*VLQ_W];
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE:   if (item_valid) state_next = EM_VLQ;
      EM_VLQ:    if (adv && grp == 2'd0) state_next = EM_STATUS;
      EM_STATUS: if (adv) state_next = EM_NOTE;
      EM_NOTE:   if (adv) state_next = EM_VEL;
      EM_VEL:    if (adv) state_next = item_valid ? EM_VLQ : EM_IDLE;
      default:   state_next = EM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_take = 1'b0;
    emit      = 1'b0;
    byte_val  = '0;
    last_val  = 1'b0;
    unique case (state)
      EM_IDLE:   item_take = item_valid;
      EM_VLQ: begin
        emit     = adv;
        byte_val = {grp != 2'd0, part};
      end
      EM_STATUS: begin
        emit     = adv;
        byte_val = off ? STATUS_OFF : STATUS_ON;
      end
      EM_NOTE: begin
        emit     = adv;
        byte_val = {1'b0, note};
      end
      EM_VEL: begin
        emit      = adv;
        byte_val  = off ? '0 : {1'b0, vel};
        last_val  = 1'b1;
        item_take = adv && item_valid;
      end
      default: begin
        item_take = 1'b0;
        emit      = 1'b0;
      end
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (track.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Event hold and output payload
  always_ff @(posedge clk) begin
    if (item_take) begin
      ticks <= item.ticks;
      off   <= item.off;
      note  <= item.note;
      vel   <= item.vel;
      grp   <= vlq_top_group(item.ticks);
    end else if (state == EM_VLQ && adv && grp != 2'd0) begin
      grp <= grp - 1'b1;
    end
    if (emit) begin
      out_byte <= byte_val;
      out_last <= last_val;
    end
  end

endmodule

`default_nettype wire

FILE: src/mnee_checker.sv
`default_nettype none

`include "midi_note_event_encoder_assert.svh"

// Port-level checks of the encoder
module mnee_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        evt_ready,
  input logic                        trk_valid,
  input logic                        trk_ready,
  input logic [mnee_pkg::BYTE_W-1:0] trk_out_byte,
  input logic                        trk_last_byte
);
  import mnee_pkg::*;

  // Reset leaves no byte pending
  `MNEE_ASSERT_RESET(a_reset_no_byte, !trk_valid, "track valid after reset")

  // Reset empties the queue, so events are taken right away
  `MNEE_ASSERT_RESET(a_reset_ready, evt_ready, "event channel not ready after reset")

  // The closing byte is a velocity, never a status or continued group
  `MNEE_ASSERT_SAME(a_last_data, trk_valid && trk_last_byte, !trk_out_byte[BYTE_W-1], "last byte has bit 7 set")

  // A stalled byte stays on the port unchanged
  `MNEE_ASSERT_NEXT(a_stall_hold, trk_valid && !trk_ready, trk_valid && $stable(trk_out_byte) && $stable(trk_last_byte), "track byte changed under stall")

endmodule

bind midi_note_event_encoder mnee_checker u_mnee_checker (
  .clk           (clk),
  .rst           (rst),
  .evt_ready     (note_evt.ready),
  .trk_valid     (track.valid),
  .trk_ready     (track.ready),
  .trk_out_byte  (track.out_byte),
  .trk_last_byte (track.last_byte)
);

`default_nettype wire
